>>> hdl/pba_pkg.sv
// Shared constants, codes and bit helpers for the page bitmap allocator.
package pba_pkg;

    localparam int PAGE_COUNT = 1048576;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    localparam int ADDR_W    = 32;
    localparam int CNT_W     = 21;
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;
    localparam int MAP_WORDS = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    // page numbers: wide enough for a 33-bit rounded address and for PAGE_COUNT itself
    localparam int PG_W_ADDR = ADDR_W + 1 - PAGE_SHIFT;
    localparam int PG_W_CNT  = $clog2(PAGE_COUNT + 1);
    localparam int PG_W      = (PG_W_ADDR > PG_W_CNT) ? PG_W_ADDR : PG_W_CNT;

    localparam int LOW_MEM_END = 32'h0010_0000;
    localparam int LOW_PAGE    = LOW_MEM_END / PAGE_BYTES;

    localparam logic [ADDR_W-1:0] KERNEL_END_RST = 32'h0010_0000;

    localparam logic [2:0] FUNC_BEGIN  = 3'd0;
    localparam logic [2:0] FUNC_ADD    = 3'd1;
    localparam logic [2:0] FUNC_FINISH = 3'd2;
    localparam logic [2:0] FUNC_ALLOC  = 3'd3;
    localparam logic [2:0] FUNC_FREE   = 3'd4;

    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_KERNEL_END = '0;

    typedef logic [WORD_BITS-1:0] t_word;

    function automatic logic [BIT_W:0] popcount(input t_word v);
        t_word x;
        x = v - ((v >> 1) & 32'h5555_5555);
        x = (x & 32'h3333_3333) + ((x >> 2) & 32'h3333_3333);
        x = (x + (x >> 4)) & 32'h0F0F_0F0F;
        x = x + (x >> 8);
        x = x + (x >> 16);
        return x[BIT_W:0];
    endfunction

    // index of the lowest set bit; 0 for an all-zero word
    function automatic logic [BIT_W-1:0] lowest_index(input t_word v);
        t_word            low;
        logic [BIT_W-1:0] idx;
        low = v & (~v + t_word'(1));
        idx = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (low[j]) begin
                idx = idx | BIT_W'(j);
            end
        end
        return idx;
    endfunction

endpackage

>>> hdl/pba_ram.sv
// Generic simple dual-port RAM with registered read.
module pba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/page_bitmap_allocator_unit.sv
// Page frame allocator: free bitmap in RAM, word-at-a-time sequencer, free page count.
// The free bitmap sits in a single-port-per-direction RAM of MAP_WORDS (32768) 32-bit words
// and is worked one word at a time by a small sequencer sharing one popcount/adder for the
// free count. After reset, and for every begin_init word, a clearing pass writes all
// MAP_WORDS words; no word is accepted during the pass after reset. allocate scans one
// bitmap word per cycle from word 0 and stops at the first nonzero word. add_region,
// finish_init and free read each bitmap word touched, then modify and write it back;
// a free touches one word. Each word yields one result word, held in an output register,
// so the next word is taken while a result still waits.
module page_bitmap_allocator_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [2:0]                       i_func,
    input  logic [31:0]                      i_region_base,
    input  logic [31:0]                      i_region_base_high,
    input  logic [31:0]                      i_region_length,
    input  logic [31:0]                      i_region_kind,
    input  logic [31:0]                      i_page_address,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [31:0]                      o_alloc_address,
    output logic                             o_alloc_found,
    output logic [20:0]                      o_free_pages,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pba_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int WAW  = pba_pkg::WORD_AW;
    localparam int BW   = pba_pkg::BIT_W;
    localparam int PGW  = pba_pkg::PG_W;
    localparam int CW   = pba_pkg::CNT_W;
    localparam int AW   = pba_pkg::ADDR_W;
    localparam logic [WAW-1:0] LAST_WORD = WAW'(pba_pkg::MAP_WORDS - 1);
    localparam logic [PGW-1:0] PG_LIMIT  = PGW'(pba_pkg::PAGE_COUNT);
    localparam logic [PGW-1:0] PG_LOW    = PGW'(pba_pkg::LOW_PAGE);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RNG_RD,
        S_RNG_WR,
        S_SCAN,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [WAW-1:0]       r_word;
    logic [WAW-1:0]       r_rd_word;
    logic                 r_pend;
    logic                 r_init_item;
    logic [WAW-1:0]       r_first_word;
    logic [WAW-1:0]       r_last_word;
    logic [BW-1:0]        r_lo_bit;
    logic [BW-1:0]        r_last_bit;
    logic                 r_set;
    logic                 r_second;
    logic [PGW-1:0]       r_top;
    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_res_addr;
    logic                 r_res_found;
    logic                 r_out_valid;
    logic [AW-1:0]        r_out_addr;
    logic                 r_out_found;
    logic [CW-1:0]        r_out_count;
    logic [AW-1:0]        r_kernel_end;

    logic                 accept;
    logic [AW-1:0]        s_addr;
    logic [AW-1:0]        e_addr;
    logic [PGW-1:0]       top;
    logic [PGW-1:0]       rs_lo;
    logic [PGW-1:0]       rs_hi;
    logic [PGW-1:0]       rs_hi_c;
    logic [PGW-1:0]       rs_last;
    logic                 rs_en;
    logic                 rs_set;
    logic                 rs_go;

    pba_pkg::t_word       rd;
    pba_pkg::t_word       m_lo;
    pba_pkg::t_word       m_hi;
    pba_pkg::t_word       mask;
    pba_pkg::t_word       chg;
    pba_pkg::t_word       new_word;
    pba_pkg::t_word       scan_low;
    logic [BW:0]          pop;
    logic [BW-1:0]        scan_idx;

    logic                 ram_we;
    logic [WAW-1:0]       ram_waddr;
    pba_pkg::t_word       ram_wdata;
    logic                 ram_re;
    logic [WAW-1:0]       ram_raddr;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // range setup: from the input word in idle, else the kernel range of finish_init
    assign s_addr = i_region_base + AW'(pba_pkg::PAGE_BYTES - 1);
    assign e_addr = i_region_base + i_region_length;
    assign top    = PGW'(({1'b0, r_kernel_end} + (AW + 1)'(pba_pkg::PAGE_BYTES - 1))
                         >> pba_pkg::PAGE_SHIFT);

    always_comb begin
        rs_lo  = '0;
        rs_hi  = '0;
        rs_en  = 1'b0;
        rs_set = 1'b0;
        if (r_state == S_IDLE) begin
            unique case (i_func)
                pba_pkg::FUNC_ADD: begin
                    rs_lo  = PGW'(s_addr >> pba_pkg::PAGE_SHIFT);
                    rs_hi  = PGW'(e_addr >> pba_pkg::PAGE_SHIFT);
                    rs_en  = (i_region_kind == 32'd1) && (i_region_base_high == '0);
                    rs_set = 1'b1;
                end
                pba_pkg::FUNC_FINISH: begin
                    rs_lo  = '0;
                    rs_hi  = PGW'(1);
                    rs_en  = 1'b1;
                end
                pba_pkg::FUNC_FREE: begin
                    rs_lo  = PGW'(i_page_address >> pba_pkg::PAGE_SHIFT);
                    rs_hi  = PGW'(i_page_address >> pba_pkg::PAGE_SHIFT) + PGW'(1);
                    rs_en  = 1'b1;
                    rs_set = 1'b1;
                end
                default: begin
                    rs_en = 1'b0;
                end
            endcase
        end else begin
            rs_lo = PG_LOW;
            rs_hi = r_top;
            rs_en = 1'b1;
        end
    end

    assign rs_hi_c = (rs_hi > PG_LIMIT) ? PG_LIMIT : rs_hi;
    assign rs_go   = rs_en && (rs_lo < rs_hi_c);
    assign rs_last = rs_hi_c - PGW'(1);

    // word modify for range marking
    assign m_lo = (r_word == r_first_word) ? ('1 << r_lo_bit) : '1;
    assign m_hi = (r_word == r_last_word) ?
                  ('1 >> (BW'(pba_pkg::WORD_BITS - 1) - r_last_bit)) : '1;
    assign mask = m_lo & m_hi;
    assign chg  = r_set ? (mask & ~rd) : (mask & rd);
    assign new_word = r_set ? (rd | mask) : (rd & ~mask);
    assign pop  = pba_pkg::popcount(chg);

    assign scan_low = rd & (~rd + pba_pkg::t_word'(1));
    assign scan_idx = pba_pkg::lowest_index(rd);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_word;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_word;
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_RNG_RD: begin
                ram_re = 1'b1;
            end
            S_RNG_WR: begin
                ram_we    = 1'b1;
                ram_wdata = new_word;
            end
            S_SCAN: begin
                ram_re = 1'b1;
                if (r_pend && (rd != '0)) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_rd_word;
                    ram_wdata = rd & ~scan_low;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    pba_ram #(
        .WIDTH(pba_pkg::WORD_BITS),
        .DEPTH(pba_pkg::MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_word      <= '0;
            r_pend      <= 1'b0;
            r_init_item <= 1'b0;
            r_second    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_word == LAST_WORD) begin
                        r_word  <= '0;
                        r_state <= r_init_item ? S_DONE : S_IDLE;
                    end else begin
                        r_word <= r_word + WAW'(1);
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_res_addr  <= '0;
                        r_res_found <= 1'b0;
                        r_top       <= top;
                        r_second    <= (i_func == pba_pkg::FUNC_FINISH);
                        if (i_func == pba_pkg::FUNC_BEGIN) begin
                            r_word      <= '0;
                            r_count     <= '0;
                            r_init_item <= 1'b1;
                            r_state     <= S_CLEAR;
                        end else if (i_func == pba_pkg::FUNC_ALLOC) begin
                            r_word  <= '0;
                            r_pend  <= 1'b0;
                            r_state <= S_SCAN;
                        end else if (rs_go) begin
                            r_word       <= rs_lo[BW +: WAW];
                            r_first_word <= rs_lo[BW +: WAW];
                            r_lo_bit     <= rs_lo[BW-1:0];
                            r_last_word  <= rs_last[BW +: WAW];
                            r_last_bit   <= rs_last[BW-1:0];
                            r_set        <= rs_set;
                            r_state      <= S_RNG_RD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_RNG_RD: begin
                    r_state <= S_RNG_WR;
                end
                S_RNG_WR: begin
                    r_count <= r_set ? (r_count + CW'(pop)) : (r_count - CW'(pop));
                    if (r_word != r_last_word) begin
                        r_word  <= r_word + WAW'(1);
                        r_state <= S_RNG_RD;
                    end else if (r_second && rs_go) begin
                        // kernel pages of finish_init
                        r_second     <= 1'b0;
                        r_word       <= rs_lo[BW +: WAW];
                        r_first_word <= rs_lo[BW +: WAW];
                        r_lo_bit     <= rs_lo[BW-1:0];
                        r_last_word  <= rs_last[BW +: WAW];
                        r_last_bit   <= rs_last[BW-1:0];
                        r_set        <= rs_set;
                        r_state      <= S_RNG_RD;
                    end else begin
                        r_second <= 1'b0;
                        r_state  <= S_DONE;
                    end
                end
                S_SCAN: begin
                    if (r_pend && (rd != '0)) begin
                        r_count     <= r_count - CW'(1);
                        r_res_found <= 1'b1;
                        r_res_addr  <= AW'({r_rd_word, scan_idx}) << pba_pkg::PAGE_SHIFT;
                        r_pend      <= 1'b0;
                        r_state     <= S_DONE;
                    end else if (r_pend && (r_rd_word == LAST_WORD)) begin
                        r_pend  <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_rd_word <= r_word;
                        r_pend    <= 1'b1;
                        r_word    <= r_word + WAW'(1);
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_addr  <= r_res_addr;
                        r_out_found <= r_res_found;
                        r_out_count <= r_count;
                        r_init_item <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_alloc_address = r_out_addr;
    assign o_alloc_found   = r_out_found;
    assign o_free_pages    = r_out_count;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_end <= pba_pkg::KERNEL_END_RST;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[pba_pkg::PADDR_W-1:2] == pba_pkg::REG_KERNEL_END)) begin
            r_kernel_end <= pwdata;
        end
    end

    assign prdata = (paddr[pba_pkg::PADDR_W-1:2] == pba_pkg::REG_KERNEL_END) ?
                    r_kernel_end : '0;
    assign pready = 1'b1;

endmodule

>>> hdl/pba_checker.sv
// Port-level assertions for the page bitmap allocator, bound to the top level.
module pba_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [31:0]                 o_alloc_address,
    input logic                        o_alloc_found,
    input logic [20:0]                 o_free_pages
);

    // one word at a time: ready drops after every accepted word
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted on consecutive cycles");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_alloc_found) |-> (o_alloc_address == '0))
        else $error("address without found page");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_free_pages <= 21'(pba_pkg::PAGE_COUNT)))
        else $error("free count beyond page count");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_alloc_address) && $stable(o_alloc_found) &&
             $stable(o_free_pages)))
        else $error("stalled result changed");

endmodule

bind page_bitmap_allocator_unit pba_checker u_pba_checker (.*);
